FILE: sv/kmpsm_pkg.sv
package kmpsm_pkg;

  localparam int MaxPatternDef = 64;
  localparam int IndexBitsDef  = 32;
  localparam int SymW          = 8;
  localparam int MatchStartW   = 32;
  localparam int OpW           = 2;

  typedef enum logic [OpW-1:0] {
    OP_APPEND = 2'd0,
    OP_TEXT   = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef struct packed {
    logic            append;
    logic            text;
    logic            clear;
    logic [SymW-1:0] symbol;
  } cell_ctrl_t;

endpackage

FILE: sv/kmp_stream_matcher_top.sv
// Streaming pattern matcher with the results of Knuth-Morris-Pratt search, built as a row of
// MAX_PATTERN cells, one per pattern byte. Each cell holds its byte and a bit that says the
// pattern prefix ending at that cell is a suffix of the text seen so far; on a text byte the
// bits move one cell down the row, gated by the byte compare, so overlapping occurrences are
// found and a completed occurrence falls back to its longest border. Op 0 appends a pattern
// byte (status 1 if the row is full and the byte is dropped), op 1 streams a text byte and
// reports match with the start index (modulo 2^INDEX_BITS, low 32 bits shown; 0 without a
// match), op 2 clears pattern and text index, op 3 is a no-op. Every item gives exactly one
// result, in the cycle after its transfer. The whole row updates in the cycle of the transfer,
// so one item is taken per clock while no held result is stalled; the output register holds
// one result, a new item is taken in the same cycle the held result leaves, and in_stall_o is
// high only while a held result is stalled.
module kmp_stream_matcher_top
  import kmpsm_pkg::*;
#(
  parameter int MAX_PATTERN = MaxPatternDef,
  parameter int INDEX_BITS  = IndexBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [OpW-1:0]         op_i,
  input  logic [SymW-1:0]        symbol_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic                   match_o,
  output logic [MatchStartW-1:0] match_start_o,
  output logic                   status_o
);

  localparam int LenW = $clog2(MAX_PATTERN + 1);

  logic                   in_xfer;
  logic                   out_xfer;
  cell_ctrl_t             ctrl;
  logic [MAX_PATTERN-1:0] valid_v, hit_v, full_hit_v;
  logic [MAX_PATTERN:0]   valid_up, hit_up, valid_dn;
  logic [MAX_PATTERN-1:0] prev_valid_v, prev_hit_v, next_valid_v;
  logic                   store_full;

  logic [LenW-1:0]        len_q, len_d;
  logic [INDEX_BITS-1:0]  idx_q, idx_d;
  logic [INDEX_BITS-1:0]  start;
  logic [63:0]            start_ext;

  logic                   out_valid_q, out_valid_d;
  logic                   match_q, match_d;
  logic [MatchStartW-1:0] start_q, start_d;
  logic                   status_q, status_d;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_xfer   = out_valid_q && !out_stall_i;

  assign ctrl.append = in_xfer && (op_i == OP_APPEND);
  assign ctrl.text   = in_xfer && (op_i == OP_TEXT);
  assign ctrl.clear  = in_xfer && (op_i == OP_CLEAR);
  assign ctrl.symbol = symbol_i;

  assign valid_up     = {valid_v, 1'b1};
  assign hit_up       = {hit_v, 1'b1};
  assign valid_dn     = {1'b0, valid_v};
  assign prev_valid_v = valid_up[MAX_PATTERN-1:0];
  assign prev_hit_v   = hit_up[MAX_PATTERN-1:0];
  assign next_valid_v = valid_dn[MAX_PATTERN:1];
  assign store_full   = valid_v[MAX_PATTERN-1];

  for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_cell
    kmpsm_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .prev_valid_i (prev_valid_v[g]),
      .prev_hit_i   (prev_hit_v[g]),
      .next_valid_i (next_valid_v[g]),
      .valid_o      (valid_v[g]),
      .hit_o        (hit_v[g]),
      .full_hit_o   (full_hit_v[g])
    );
  end

  assign start     = idx_q - INDEX_BITS'(len_q) + INDEX_BITS'(1);
  assign start_ext = 64'(start);

  always_comb begin
    len_d = len_q;
    idx_d = idx_q;
    if (ctrl.clear) begin
      len_d = '0;
      idx_d = '0;
    end else if (ctrl.append && !store_full) begin
      len_d = len_q + LenW'(1);
    end else if (ctrl.text) begin
      idx_d = idx_q + INDEX_BITS'(1);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    match_d     = match_q;
    start_d     = start_q;
    status_d    = status_q;
    if (in_xfer) begin
      out_valid_d = 1'b1;
      match_d     = |full_hit_v;
      start_d     = (|full_hit_v) ? start_ext[MatchStartW-1:0] : '0;
      status_d    = ctrl.append && store_full;
    end else if (out_xfer) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      len_q       <= len_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    match_q  <= match_d;
    start_q  <= start_d;
    status_q <= status_d;
  end

  assign out_valid_o   = out_valid_q;
  assign match_o       = match_q;
  assign match_start_o = start_q;
  assign status_o      = status_q;

`ifndef SYNTHESIS
  a_len_tracks_cells: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_v) == int'(len_q))
    else $error("pattern length disagrees with loaded cells");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.clear |=> (len_q == '0) && (idx_q == '0) && (hit_v == '0))
    else $error("clear left pattern or match state behind");

  a_match_excl_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(match_o && status_o))
    else $error("match and drop status in one result");

  a_no_match_zero_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !match_o |-> match_start_o == '0)
    else $error("start index set without a match");
`endif

endmodule

FILE: sv/kmpsm_cell.sv
module kmpsm_cell
  import kmpsm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  logic       prev_valid_i,
  input  logic       prev_hit_i,
  input  logic       next_valid_i,
  output logic       valid_o,
  output logic       hit_o,
  output logic       full_hit_o
);

  logic            valid_q, valid_d;
  logic            hit_q, hit_d;
  logic [SymW-1:0] byte_q;
  logic            load;
  logic            last;
  logic            hit_new;

  assign load    = ctrl_i.append && prev_valid_i && !valid_q;
  assign last    = valid_q && !next_valid_i;
  assign hit_new = prev_hit_i && valid_q && (byte_q == ctrl_i.symbol);

  always_comb begin
    valid_d = valid_q;
    hit_d   = hit_q;
    if (ctrl_i.clear) begin
      valid_d = 1'b0;
      hit_d   = 1'b0;
    end else if (load) begin
      valid_d = 1'b1;
    end else if (ctrl_i.text) begin
      // a completed occurrence drops back to the next shorter border
      hit_d = hit_new && !last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      hit_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      hit_q   <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= ctrl_i.symbol;
    end
  end

  assign valid_o    = valid_q;
  assign hit_o      = hit_q;
  assign full_hit_o = ctrl_i.text && hit_new && last;

endmodule
